// ----- hdl/rfm_pkg.sv -----
// rfm_pkg: item types, datapath command and status types, register indexes
// for the regression fit metrics unit; no dependencies
package rfm_pkg;

  localparam int unsigned ADDR_W    = 5;
  localparam int unsigned REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_COEF_0     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_COEF_1     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COEF_2     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_COEF_3     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TOTAL_MODE = 3'd4;

  // square operand select
  localparam logic [1:0] SQ_OBS  = 2'd0;
  localparam logic [1:0] SQ_PRED = 2'd1;
  localparam logic [1:0] SQ_RES  = 2'd2;
  localparam logic [1:0] SQ_X    = 2'd3;

  // divide job select
  localparam logic [1:0] DIV_MEAN = 2'd0;
  localparam logic [1:0] DIV_YBAR = 2'd1;
  localparam logic [1:0] DIV_PBAR = 2'd2;
  localparam logic [1:0] DIV_RSQ  = 2'd3;

  // total sum pass select
  localparam logic [1:0] PASS_Y = 2'd0;
  localparam logic [1:0] PASS_P = 2'd1;
  localparam logic [1:0] PASS_D = 2'd2;

  typedef struct packed {
    logic signed [31:0] feat_0;
    logic signed [31:0] feat_1;
    logic signed [31:0] feat_2;
    logic signed [31:0] feat_3;
    logic signed [31:0] observed;
    logic               last_row;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] residual;
    logic        [30:0] rmse;
    logic signed [31:0] r_squared;
    logic               stats_valid;
    logic               fit_error;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_FEAT,
    OP_ACC_PRED,
    OP_RESID,
    OP_MUL_SQ,
    OP_ACC_SQ,
    OP_DIV,
    OP_TAKE_DIV,
    OP_SQRT,
    OP_TAKE_RMSE,
    OP_X_DIFF,
    OP_TAKE_S,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_TAKE_T,
    OP_COMB,
    OP_ADD_RES,
    OP_CHK,
    OP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic upd;
    logic last;
    logic count_zero;
    logic mean_big;
    logic mode;
    logic out_free;
    logic total_zero;
  } status_t;

endpackage

// ----- hdl/rfm_div.sv -----
// rfm_div: restoring divider, one quotient bit per cycle
// 64-bit divisor; standalone, no package use
module rfm_div #(
  parameter int unsigned DW = 80
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [63:0]   divisor_i,
  output logic [DW-1:0] quotient_o,
  output logic          done_o
);

  localparam int unsigned CNTW = $clog2(DW);

  logic [DW-1:0]   dvd_q, dvd_d;
  logic [63:0]     rem_q, rem_d;
  logic [63:0]     dvs_q;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [64:0]     shifted;
  logic            ge;

  assign shifted = {rem_q, dvd_q[DW-1]};
  assign ge      = shifted >= {1'b0, dvs_q};

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = CNTW'(DW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? 64'(shifted - {1'b0, dvs_q}) : shifted[63:0];
      dvd_d = {dvd_q[DW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    if (start_i) dvs_q <= divisor_i;
  end

  assign quotient_o = dvd_q;
  assign done_o     = done_q;

endmodule

// ----- hdl/rfm_isqrt.sv -----
// rfm_isqrt: bit-pair integer square root, one result bit per cycle
// radicand below 2^62; standalone, no package use
module rfm_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] radicand_i,
  output logic [31:0] root_o,
  output logic        done_o
);

  logic [63:0] x_q, x_d, r_q, r_d, bit_q, bit_d, trial;
  logic        busy_q, busy_d, done_q, done_d, ge;

  assign trial = r_q + bit_q;
  assign ge    = x_q >= trial;

  always_comb begin
    x_d    = x_q;
    r_d    = r_q;
    bit_d  = bit_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      x_d    = radicand_i;
      r_d    = '0;
      bit_d  = 64'h4000_0000_0000_0000;
      busy_d = 1'b1;
    end else if (busy_q) begin
      x_d   = ge ? x_q - trial : x_q;
      r_d   = ge ? (r_q >> 1) + bit_q : r_q >> 1;
      bit_d = bit_q >> 2;
      if (bit_q[0]) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    r_q   <= r_d;
    bit_q <= bit_d;
  end

  assign root_o = r_q[31:0];
  assign done_o = done_q;

endmodule

// ----- hdl/rfm_dp.sv -----
// rfm_dp: datapath with shared multiplier, running sums, divider, square root
// and result register; uses rfm_pkg, rfm_div, rfm_isqrt
module rfm_dp import rfm_pkg::*; #(
  parameter int unsigned MAX_ROWS  = 65536,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cmd_t            cmd_i,
  output status_t         status_o,
  input  in_item_t        in_data_i,
  input  logic [3:0][31:0] coef_i,
  input  logic            mode_i,
  output out_item_t       out_data_o,
  output logic            out_valid_o,
  input  logic            out_ready_i
);

  localparam int unsigned CW = $clog2(MAX_ROWS + 1);
  localparam int unsigned SW = 33 + $clog2(MAX_ROWS);
  localparam int unsigned DW = 64 + FRAC_BITS;
  localparam logic [63:0] U64_MAX = '1;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? U64_MAX : s[63:0];
  endfunction

  function automatic logic [63:0] sub0(input logic [63:0] a, input logic [63:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : v;
  endfunction

  in_item_t           in_q;
  logic signed [63:0] acc_q;
  logic signed [31:0] pred_q, res_q, ybar_q, pbar_q, x_q;
  logic [CW-1:0]      cnt_q;
  logic signed [SW-1:0] sy_q, sp_q;
  logic [63:0]        syy_q, spp_q, srr_q;
  logic [63:0]        prod_q, lo_q, s_q, t_q, ss_q, mean_q;
  logic [30:0]        rmse_q;
  logic signed [31:0] rsq_q;
  logic               err_q;
  out_item_t          out_q;
  logic               out_valid_q;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [31:0] feat_sel;
  logic [31:0]        sq_mag;
  logic [32:0]        n33;
  logic [63:0]        n64, sq_val;
  logic signed [63:0] obs_w, res_w;
  logic               upd;
  logic [SW-1:0]      sy_mag, sp_mag;
  logic [DW-1:0]      div_dvd, div_q;
  logic [63:0]        div_dvs;
  logic               div_done, sqrt_done, mean_big;
  logic [31:0]        root;
  logic [95:0]        nsum;
  logic signed [32:0] qsigned;
  logic signed [33:0] rv;
  logic signed [63:0] xdiff;

  assign n33    = {{(33-CW){1'b0}}, cnt_q};
  assign n64    = {{(64-CW){1'b0}}, cnt_q};
  assign upd    = cnt_q < CW'(MAX_ROWS);
  assign obs_w  = 64'(in_q.observed);
  assign res_w  = obs_w - acc_q;
  assign sq_val = prod_q >> FRAC_BITS;
  assign mean_big = |mean_q[63:62-FRAC_BITS];
  assign sy_mag = sy_q[SW-1] ? SW'(-sy_q) : sy_q;
  assign sp_mag = sp_q[SW-1] ? SW'(-sp_q) : sp_q;
  assign nsum   = {prod_q, 32'd0} + {32'd0, lo_q};
  assign xdiff  = 64'(pbar_q) - 64'(ybar_q);

  // shared multiplier operand select
  always_comb begin
    case (cmd_i.idx)
      2'd0:    feat_sel = in_q.feat_0;
      2'd1:    feat_sel = in_q.feat_1;
      2'd2:    feat_sel = in_q.feat_2;
      default: feat_sel = in_q.feat_3;
    endcase
    case (cmd_i.idx)
      SQ_OBS:  sq_mag = mag32(in_q.observed);
      SQ_PRED: sq_mag = mag32(pred_q);
      SQ_RES:  sq_mag = mag32(res_q);
      default: sq_mag = mag32(x_q);
    endcase
    case (cmd_i.op)
      OP_MUL_FEAT: begin
        mul_a = 33'(feat_sel);
        mul_b = 33'($signed(coef_i[cmd_i.idx]));
      end
      OP_MUL_LO: begin
        mul_a = n33;
        mul_b = {1'b0, s_q[31:0]};
      end
      OP_MUL_HI: begin
        mul_a = n33;
        mul_b = {1'b0, s_q[63:32]};
      end
      default: begin
        mul_a = {1'b0, sq_mag};
        mul_b = {1'b0, sq_mag};
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    case (cmd_i.idx)
      DIV_MEAN: begin
        div_dvd = {{(DW-64){1'b0}}, srr_q};
        div_dvs = n64;
      end
      DIV_YBAR: begin
        div_dvd = {{(DW-SW){1'b0}}, sy_mag};
        div_dvs = n64;
      end
      DIV_PBAR: begin
        div_dvd = {{(DW-SW){1'b0}}, sp_mag};
        div_dvs = n64;
      end
      default: begin
        div_dvd = {srr_q, {FRAC_BITS{1'b0}}};
        div_dvs = ss_q;
      end
    endcase
    qsigned = {1'b0, div_q[31:0]};
    rv = $signed({2'b00, 32'(1) << FRAC_BITS}) - $signed({2'b00, div_q[31:0]});
  end

  rfm_div #(.DW(DW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.op == OP_DIV),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .quotient_o (div_q),
    .done_o     (div_done)
  );

  rfm_isqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    ((cmd_i.op == OP_SQRT) && !mean_big),
    .radicand_i (mean_q << FRAC_BITS),
    .root_o     (root),
    .done_o     (sqrt_done)
  );

  // running sums and item control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      sy_q        <= '0;
      sp_q        <= '0;
      syy_q       <= '0;
      spp_q       <= '0;
      srr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_OUT) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (cmd_i.op)
        OP_RESID: begin
          if (upd) begin
            cnt_q <= cnt_q + 1'b1;
            sy_q  <= sy_q + SW'(in_q.observed);
            sp_q  <= sp_q + SW'(sat32(acc_q));
          end
        end
        OP_ACC_SQ: begin
          case (cmd_i.idx)
            SQ_OBS:  syy_q <= add_sat(syy_q, sq_val);
            SQ_PRED: spp_q <= add_sat(spp_q, sq_val);
            default: srr_q <= add_sat(srr_q, sq_val);
          endcase
        end
        OP_OUT: begin
          if (in_q.last_row) begin
            cnt_q <= '0;
            sy_q  <= '0;
            sp_q  <= '0;
            syy_q <= '0;
            spp_q <= '0;
            srr_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        in_q   <= in_data_i;
        acc_q  <= '0;
        rmse_q <= '0;
        rsq_q  <= '0;
        err_q  <= 1'b0;
      end
      OP_MUL_FEAT, OP_MUL_SQ, OP_MUL_LO: prod_q <= mul_p[63:0];
      OP_MUL_HI: begin
        lo_q   <= prod_q;
        prod_q <= mul_p[63:0];
      end
      OP_ACC_PRED: acc_q <= acc_q + ($signed(prod_q) >>> FRAC_BITS);
      OP_RESID: begin
        pred_q <= sat32(acc_q);
        res_q  <= sat32(res_w);
      end
      OP_TAKE_DIV: begin
        case (cmd_i.idx)
          DIV_MEAN: mean_q <= div_q[63:0];
          DIV_YBAR: begin
            ybar_q <= sy_q[SW-1] ? 32'(-qsigned) : 32'(qsigned);
            x_q    <= sy_q[SW-1] ? 32'(-qsigned) : 32'(qsigned);
          end
          DIV_PBAR: begin
            pbar_q <= sp_q[SW-1] ? 32'(-qsigned) : 32'(qsigned);
            x_q    <= sp_q[SW-1] ? 32'(-qsigned) : 32'(qsigned);
          end
          default: begin
            if (|div_q[DW-1:32]) rsq_q <= 32'sh8000_0000;
            else if (rv < -34'sd2147483648) rsq_q <= 32'sh8000_0000;
            else rsq_q <= rv[31:0];
          end
        endcase
      end
      OP_SQRT: if (mean_big) rmse_q <= 31'h7fff_ffff;
      OP_TAKE_RMSE: rmse_q <= root[30:0];
      OP_X_DIFF: x_q <= sat32(xdiff);
      OP_TAKE_S: s_q <= sq_val;
      OP_TAKE_T: t_q <= (|nsum[95:64]) ? U64_MAX : nsum[63:0];
      OP_COMB: begin
        case (cmd_i.idx)
          PASS_Y:  ss_q <= sub0(syy_q, t_q);
          PASS_P:  ss_q <= sub0(spp_q, t_q);
          default: ss_q <= add_sat(ss_q, t_q);
        endcase
      end
      OP_ADD_RES: ss_q <= add_sat(ss_q, srr_q);
      OP_CHK: err_q <= (ss_q == '0);
      OP_OUT: begin
        out_q.residual    <= res_q;
        out_q.rmse        <= rmse_q;
        out_q.r_squared   <= rsq_q;
        out_q.stats_valid <= in_q.last_row;
        out_q.fit_error   <= in_q.last_row & (err_q | (cnt_q == '0));
      end
      default: ;
    endcase
  end

  assign status_o.div_done   = div_done;
  assign status_o.sqrt_done  = sqrt_done;
  assign status_o.upd        = upd;
  assign status_o.last       = in_q.last_row;
  assign status_o.count_zero = (cnt_q == '0);
  assign status_o.mean_big   = mean_big;
  assign status_o.mode       = mode_i;
  assign status_o.out_free   = !out_valid_q || out_ready_i;
  assign status_o.total_zero = err_q;

  assign out_data_o  = out_q;
  assign out_valid_o = out_valid_q;

endmodule

// ----- hdl/rfm_ctrl.sv -----
// rfm_ctrl: sequencer that steps the datapath through one row and, on the
// last row, through the fit statistics; uses rfm_pkg
module rfm_ctrl import rfm_pkg::*; #(
  parameter int unsigned NUM_FEATURES = 4
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [25:0] {
    S_IDLE    = 26'h0000001,
    S_MUL_F   = 26'h0000002,
    S_ACC_F   = 26'h0000004,
    S_RESID   = 26'h0000008,
    S_MUL_SQ  = 26'h0000010,
    S_ACC_SQ  = 26'h0000020,
    S_DIV_M   = 26'h0000040,
    S_W_DIV_M = 26'h0000080,
    S_SQRT    = 26'h0000100,
    S_W_SQRT  = 26'h0000200,
    S_DIV_Y   = 26'h0000400,
    S_W_DIV_Y = 26'h0000800,
    S_DIV_P   = 26'h0001000,
    S_W_DIV_P = 26'h0002000,
    S_X_DIFF  = 26'h0004000,
    S_MUL_X   = 26'h0008000,
    S_TAKE_S  = 26'h0010000,
    S_MUL_LO  = 26'h0020000,
    S_MUL_HI  = 26'h0040000,
    S_TAKE_T  = 26'h0080000,
    S_COMB    = 26'h0100000,
    S_ADD_RES = 26'h0200000,
    S_CHK     = 26'h0400000,
    S_DIV_R   = 26'h0800000,
    S_W_DIV_R = 26'h1000000,
    S_OUT     = 26'h2000000
  } state_e;

  state_e     state_q, state_d, row_end;
  logic [1:0] k_q, k_d, j_q, j_d, pass_q, pass_d;

  // statistics only on a last row with rows counted
  assign row_end = (status_i.last && !status_i.count_zero) ? S_DIV_M : S_OUT;

  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    j_d       = j_q;
    pass_d    = pass_q;
    cmd_o.op  = OP_NONE;
    cmd_o.idx = 2'd0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          k_d      = 2'd0;
          state_d  = S_MUL_F;
        end
      end
      S_MUL_F: begin
        cmd_o.op  = OP_MUL_FEAT;
        cmd_o.idx = k_q;
        state_d   = S_ACC_F;
      end
      S_ACC_F: begin
        cmd_o.op = OP_ACC_PRED;
        if (k_q == 2'(NUM_FEATURES - 1)) begin
          state_d = S_RESID;
        end else begin
          k_d     = k_q + 2'd1;
          state_d = S_MUL_F;
        end
      end
      S_RESID: begin
        cmd_o.op = OP_RESID;
        j_d      = SQ_OBS;
        state_d  = status_i.upd ? S_MUL_SQ : row_end;
      end
      S_MUL_SQ: begin
        cmd_o.op  = OP_MUL_SQ;
        cmd_o.idx = j_q;
        state_d   = S_ACC_SQ;
      end
      S_ACC_SQ: begin
        cmd_o.op  = OP_ACC_SQ;
        cmd_o.idx = j_q;
        if (j_q == SQ_RES) begin
          state_d = row_end;
        end else begin
          j_d     = j_q + 2'd1;
          state_d = S_MUL_SQ;
        end
      end
      S_DIV_M: begin
        cmd_o.op  = OP_DIV;
        cmd_o.idx = DIV_MEAN;
        state_d   = S_W_DIV_M;
      end
      S_W_DIV_M: begin
        cmd_o.idx = DIV_MEAN;
        if (status_i.div_done) begin
          cmd_o.op = OP_TAKE_DIV;
          state_d  = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd_o.op = OP_SQRT;
        state_d  = status_i.mean_big ? S_DIV_Y : S_W_SQRT;
      end
      S_W_SQRT: begin
        if (status_i.sqrt_done) begin
          cmd_o.op = OP_TAKE_RMSE;
          state_d  = S_DIV_Y;
        end
      end
      S_DIV_Y: begin
        cmd_o.op  = OP_DIV;
        cmd_o.idx = DIV_YBAR;
        state_d   = S_W_DIV_Y;
      end
      S_W_DIV_Y: begin
        cmd_o.idx = DIV_YBAR;
        if (status_i.div_done) begin
          cmd_o.op = OP_TAKE_DIV;
          pass_d   = PASS_Y;
          state_d  = status_i.mode ? S_MUL_X : S_DIV_P;
        end
      end
      S_DIV_P: begin
        cmd_o.op  = OP_DIV;
        cmd_o.idx = DIV_PBAR;
        state_d   = S_W_DIV_P;
      end
      S_W_DIV_P: begin
        cmd_o.idx = DIV_PBAR;
        if (status_i.div_done) begin
          cmd_o.op = OP_TAKE_DIV;
          pass_d   = PASS_P;
          state_d  = S_MUL_X;
        end
      end
      S_X_DIFF: begin
        cmd_o.op = OP_X_DIFF;
        pass_d   = PASS_D;
        state_d  = S_MUL_X;
      end
      S_MUL_X: begin
        cmd_o.op  = OP_MUL_SQ;
        cmd_o.idx = SQ_X;
        state_d   = S_TAKE_S;
      end
      S_TAKE_S: begin
        cmd_o.op = OP_TAKE_S;
        state_d  = S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd_o.op = OP_MUL_LO;
        state_d  = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd_o.op = OP_MUL_HI;
        state_d  = S_TAKE_T;
      end
      S_TAKE_T: begin
        cmd_o.op = OP_TAKE_T;
        state_d  = S_COMB;
      end
      S_COMB: begin
        cmd_o.op  = OP_COMB;
        cmd_o.idx = pass_q;
        case (pass_q)
          PASS_Y:  state_d = S_CHK;
          PASS_P:  state_d = S_X_DIFF;
          default: state_d = S_ADD_RES;
        endcase
      end
      S_ADD_RES: begin
        cmd_o.op = OP_ADD_RES;
        state_d  = S_CHK;
      end
      S_CHK: begin
        cmd_o.op = OP_CHK;
        state_d  = S_DIV_R;
      end
      S_DIV_R: begin
        // a zero total was flagged by the check, skip the quotient
        cmd_o.idx = DIV_RSQ;
        if (status_i.total_zero) begin
          state_d = S_OUT;
        end else begin
          cmd_o.op = OP_DIV;
          state_d  = S_W_DIV_R;
        end
      end
      S_W_DIV_R: begin
        cmd_o.idx = DIV_RSQ;
        if (status_i.div_done) begin
          cmd_o.op = OP_TAKE_DIV;
          state_d  = S_OUT;
        end
      end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.op = OP_OUT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
      j_q     <= '0;
      pass_q  <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      j_q     <= j_d;
      pass_q  <= pass_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

// ----- hdl/regression_fit_metrics_unit.sv -----
// regression_fit_metrics_unit: top level with register file, controller and
// datapath; uses rfm_pkg, rfm_ctrl, rfm_dp
//
//   channel   signals                          payload
//   in        in_valid_i / in_ready_o          in_data_i  (in_item_t)
//   out       out_valid_o / out_ready_i        out_data_o (out_item_t)
//   config    psel penable pwrite paddr pwdata  prdata, pready always high
//
// a row steps through the shared multiplier for each feature and each square;
// the squares are skipped once the row limit is reached
// a last row adds up to four runs of the bit-serial divider
// (three in mode 1, the quotient run skipped on a zero total), a square root
// run (skipped on a large mean) and the sequencing steps
// the next row is taken while a result waits in the output register
// reset clears configuration, running sums and control; no clearing pass
module regression_fit_metrics_unit import rfm_pkg::*; #(
  parameter int unsigned NUM_FEATURES = 4,
  parameter int unsigned MAX_ROWS     = 65536,
  parameter int unsigned FRAC_BITS    = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_item_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [3:0][31:0]     coef_q;
  logic                 mode_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;
  cmd_t                 cmd;
  status_t              status;

  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
      mode_q <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_COEF_0:     coef_q[0] <= pwdata;
        REG_COEF_1:     coef_q[1] <= pwdata;
        REG_COEF_2:     coef_q[2] <= pwdata;
        REG_COEF_3:     coef_q[3] <= pwdata;
        REG_TOTAL_MODE: mode_q    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_COEF_0:     prdata = coef_q[0];
      REG_COEF_1:     prdata = coef_q[1];
      REG_COEF_2:     prdata = coef_q[2];
      REG_COEF_3:     prdata = coef_q[3];
      REG_TOTAL_MODE: prdata = {31'd0, mode_q};
      default:        prdata = '0;
    endcase
  end

  rfm_ctrl #(.NUM_FEATURES(NUM_FEATURES)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rfm_dp #(.MAX_ROWS(MAX_ROWS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .coef_i      (coef_q),
    .mode_i      (mode_q),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i)
  );

endmodule

// ----- dv/regression_fit_metrics_unit_chk.sv -----
// regression_fit_metrics_unit_chk: watches the row, result and register ports,
// predicts every result and compares it; depends on rfm_pkg
`timescale 1ns / 1ps
module regression_fit_metrics_unit_chk import rfm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  in_item_t          in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  out_item_t         out_data_i,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int                fail_count_o,
  output int                pending_o
);

  localparam int unsigned FRAC      = 16;
  localparam int unsigned ROW_LIMIT = 65536;
  localparam logic [63:0] U64_MAX   = 64'hFFFF_FFFF_FFFF_FFFF;

  logic signed [31:0] coef_q [4];
  logic               mode_q;
  logic [63:0]        n_rows;
  longint             acc_obs, acc_pred;
  logic [63:0]        acc_obs_sq, acc_pred_sq, acc_res_sq;
  out_item_t          expected_q [$];
  int                 fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_q.size();

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [63:0] square_q(longint v);
    logic [63:0] a;
    a = (v < 0) ? -v : v;
    return (a * a) >> FRAC;
  endfunction

  function automatic logic [63:0] add_s(logic [63:0] a, logic [63:0] b);
    return (a > U64_MAX - b) ? U64_MAX : a + b;
  endfunction

  function automatic logic [63:0] mul_s(logic [63:0] a, logic [63:0] b);
    if (a != 0 && b > U64_MAX / a) return U64_MAX;
    return a * b;
  endfunction

  function automatic logic [63:0] isqrt(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic out_item_t fit_row(in_item_t row);
    longint      pw, pv, rv, ybar, pbar;
    logic [63:0] mean, tot, reg_ss, qi, rem, q;
    out_item_t   o;
    pw = 0;
    o  = '0;
    pw += (longint'(row.feat_0) * longint'(coef_q[0])) >>> FRAC;
    pw += (longint'(row.feat_1) * longint'(coef_q[1])) >>> FRAC;
    pw += (longint'(row.feat_2) * longint'(coef_q[2])) >>> FRAC;
    pw += (longint'(row.feat_3) * longint'(coef_q[3])) >>> FRAC;
    pv = sat32(pw);
    rv = sat32(longint'(row.observed) - pw);
    if (n_rows < ROW_LIMIT) begin
      n_rows++;
      acc_obs     += longint'(row.observed);
      acc_obs_sq   = add_s(acc_obs_sq, square_q(longint'(row.observed)));
      acc_pred    += pv;
      acc_pred_sq  = add_s(acc_pred_sq, square_q(pv));
      acc_res_sq   = add_s(acc_res_sq, square_q(rv));
    end
    o.residual = rv[31:0];
    if (row.last_row) begin
      o.stats_valid = 1'b1;
      if (n_rows == 0) begin
        o.fit_error = 1'b1;
      end else begin
        mean = acc_res_sq / n_rows;
        ybar = acc_obs / longint'(n_rows);
        if (mean >= (64'd1 << (62 - FRAC))) o.rmse = 31'h7FFF_FFFF;
        else o.rmse = 31'(isqrt(mean << FRAC));
        if (mode_q) begin
          tot = acc_obs_sq > mul_s(n_rows, square_q(ybar)) ?
                acc_obs_sq - mul_s(n_rows, square_q(ybar)) : 0;
        end else begin
          pbar   = acc_pred / longint'(n_rows);
          reg_ss = acc_pred_sq > mul_s(n_rows, square_q(pbar)) ?
                   acc_pred_sq - mul_s(n_rows, square_q(pbar)) : 0;
          reg_ss = add_s(reg_ss, mul_s(n_rows, square_q(sat32(pbar - ybar))));
          tot    = add_s(reg_ss, acc_res_sq);
        end
        if (tot == 0) begin
          o.fit_error = 1'b1;
        end else begin
          qi  = acc_res_sq / tot;
          rem = acc_res_sq % tot;
          if (qi >= (64'd1 << (32 - FRAC))) begin
            o.r_squared = 32'h8000_0000;
          end else begin
            q = qi;
            for (int i = 0; i < FRAC; i++) begin
              q = q << 1;
              if (rem >= tot - rem) begin
                rem = rem - (tot - rem);
                q   = q | 1;
              end else begin
                rem = rem + rem;
              end
            end
            o.r_squared = 32'(sat32(longint'(64'd1 << FRAC) - longint'(q)));
          end
        end
      end
      n_rows      = 0;
      acc_obs     = 0;
      acc_pred    = 0;
      acc_obs_sq  = 0;
      acc_pred_sq = 0;
      acc_res_sq  = 0;
    end
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    logic [REG_IDX_W-1:0] idx;
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) coef_q[i] = '0;
      mode_q      = 1'b0;
      n_rows      = 0;
      acc_obs     = 0;
      acc_pred    = 0;
      acc_obs_sq  = 0;
      acc_pred_sq = 0;
      acc_res_sq  = 0;
      fails       = 0;
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        idx = paddr[ADDR_W-1:2];
        case (idx)
          REG_COEF_0:     coef_q[0] = pwdata;
          REG_COEF_1:     coef_q[1] = pwdata;
          REG_COEF_2:     coef_q[2] = pwdata;
          REG_COEF_3:     coef_q[3] = pwdata;
          REG_TOTAL_MODE: mode_q    = pwdata[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) expected_q.push_back(fit_row(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result %h", $time, out_data_i);
        end else begin
          want = expected_q.pop_front();
          if (out_data_i.residual !== want.residual ||
              out_data_i.rmse !== want.rmse ||
              out_data_i.r_squared !== want.r_squared ||
              out_data_i.stats_valid !== want.stats_valid ||
              out_data_i.fit_error !== want.fit_error) begin
            fails++;
            $display("%0t: mismatch expected res=%h rmse=%h rsq=%h sv=%b err=%b",
                     $time, want.residual, want.rmse, want.r_squared,
                     want.stats_valid, want.fit_error);
            $display("%0t:          actual   res=%h rmse=%h rsq=%h sv=%b err=%b",
                     $time, out_data_i.residual, out_data_i.rmse,
                     out_data_i.r_squared, out_data_i.stats_valid,
                     out_data_i.fit_error);
          end
        end
      end
    end
  end

endmodule

// ----- dv/regression_fit_metrics_unit_tb.sv -----
// regression_fit_metrics_unit_tb: stimulus and verdict for the regression
// fit metrics unit; uses rfm_pkg, regression_fit_metrics_unit, its checker
`timescale 1ns / 1ps
module regression_fit_metrics_unit_tb;
  import rfm_pkg::*;

  localparam int WATCHDOG = 20000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  in_item_t          in_data_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  out_item_t         out_data_o;
  logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              row_taken;
  logic              calm = 1'b0;
  int                fail_count, pending, stuck;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  regression_fit_metrics_unit u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  regression_fit_metrics_unit_chk u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) row_taken <= in_valid_i && in_ready_o;

  always @(negedge clk_i) out_ready_i <= calm || ($urandom_range(0, 99) >= 20);

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) stuck <= 0;
    else stuck <= stuck + 1;
    if (stuck > WATCHDOG) begin
      $display("** regression_fit_metrics_unit: FAILED **");
      $finish;
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2, 3: return 32'($signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000);
      default: return $urandom;
    endcase
  endfunction

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // called at a falling edge with the bus idle
  task automatic wait_drained();
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic send_row(logic [31:0] f0, logic [31:0] f1, logic [31:0] f2,
                          logic [31:0] f3, logic [31:0] obs, logic last);
    while (!calm && $urandom_range(0, 99) < 20) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{f0, f1, f2, f3, obs, last};
    do @(negedge clk_i); while (!row_taken);
  endtask

  task automatic set_coefs(logic [31:0] c0, logic [31:0] c1, logic [31:0] c2,
                           logic [31:0] c3, logic [31:0] mode);
    in_valid_i <= 1'b0;
    wait_drained();
    write_reg(REG_COEF_0, c0);
    write_reg(REG_COEF_1, c1);
    write_reg(REG_COEF_2, c2);
    write_reg(REG_COEF_3, c3);
    write_reg(REG_TOTAL_MODE, mode);
  endtask

  initial begin
    int sent, len;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset coefficients: zero total on an all-zero set, then extremes
    send_row(0, 0, 0, 0, 0, 1'b1);
    send_row(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 1'b0);
    send_row(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 1'b1);
    send_row($urandom, $urandom, $urandom, $urandom, 32'h0001_0000, 1'b1);
    // extreme coefficients saturate prediction and residual
    set_coefs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    send_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h8000_0000, 1'b0);
    send_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h7FFF_FFFF, 1'b1);
    set_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'hFFFF_FFFE);
    // out-of-range indexes must be ignored
    write_reg(3'd5, $urandom);
    write_reg(3'd7, $urandom);
    send_row(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 0, 1'b0);
    send_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 0, 1'b1);
    // mean-of-observed total: zero with a constant observed value, then nonzero
    set_coefs(32'h0001_0000, 32'hFFFF_0000, 0, 32'h0000_8000, 1);
    send_row(32'h0002_0000, 32'h0001_0000, 0, 0, 32'h0003_0000, 1'b0);
    send_row(32'h0005_0000, 32'h0000_8000, 0, 0, 32'h0003_0000, 1'b0);
    send_row(32'h0001_0000, 32'h0004_0000, 0, 0, 32'h0003_0000, 1'b1);
    send_row(32'h0003_0000, 32'h0001_0000, 0, 0, 32'h0001_0000, 1'b0);
    send_row(32'h0001_0000, 32'h0002_0000, 0, 0, 32'h0007_0000, 1'b1);

    // random data sets under several register settings
    sent = 0;
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7) set_coefs(0, 0, 0, 0, 0);
      else if (ph[0]) set_coefs(pick_word(), pick_word(), pick_word(), pick_word(),
                                $urandom);
      else set_coefs(32'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000),
                     32'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000),
                     32'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000),
                     32'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000), $urandom);
      for (int s = 0; s < 250; ) begin
        calm = (sent >= 800 && sent < 1100);
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        for (int r = 0; r < len; r++) begin
          send_row(pick_word(), pick_word(), pick_word(), pick_word(), pick_word(),
                   r == len - 1);
          s++;
          sent++;
        end
      end
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (500) @(negedge clk_i);
    if (fail_count == 0) $display("** regression_fit_metrics_unit: PASSED **");
    else $display("** regression_fit_metrics_unit: FAILED **");
    $finish;
  end

endmodule
